### design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define AST_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### design/aes_zsc_pkg.sv
// Package with types, constants and GF(2^8) functions for the AES zero S-box core.
package aes_zsc_pkg;

	localparam int unsigned NumRounds = 10;
	localparam logic [8:0] GfPoly = 9'h11b;

	typedef struct packed {
		logic [63:0] key_high;
		logic [63:0] key_low;
		logic [63:0] text_high;
		logic [63:0] text_low;
	} in_item_t;

	typedef struct packed {
		logic [63:0] cipher_high;
		logic [63:0] cipher_low;
		logic        zero_sbox_hit;
	} out_item_t;

	// Data handed from one round cell to the next.
	typedef struct packed {
		logic         vld;
		logic [127:0] state;
		logic [127:0] rkey;
		logic [7:0]   rcon;
		logic         hit;
	} cell_bus_t;

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? GfPoly[7:0] : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
		logic [7:0] a;
		logic [7:0] acc;
		a = x;
		acc = 8'h00;
		for (int k = 0; k < 8; k++) begin
			if (y[k]) acc = acc ^ a;
			a = xtime(a);
		end
		gf_mul = acc;
	endfunction

	function automatic logic [7:0] sub_byte_f(input logic [7:0] x);
		logic [7:0] inv;
		inv = 8'h00;
		for (int v = 1; v < 256; v++) begin
			if (gf_mul(x, 8'(v)) == 8'h01) inv = 8'(v);
		end
		sub_byte_f = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
			^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
	endfunction

	// S-box as a 256 entry constant table.
	function automatic logic [2047:0] sbox_table_f();
		logic [2047:0] t;
		t = '0;
		for (int i = 0; i < 256; i++) t[i*8 +: 8] = sub_byte_f(8'(i));
		sbox_table_f = t;
	endfunction

	localparam logic [2047:0] SboxTable = sbox_table_f();

	function automatic logic [7:0] sbox(input logic [7:0] x);
		sbox = SboxTable[{x, 3'b000} +: 8];
	endfunction

	// Byte k of a 128 bit block, byte 0 in the top bits.
	function automatic logic [7:0] byte_of(input logic [127:0] b, input int k);
		byte_of = b[127 - 8*k -: 8];
	endfunction

endpackage

### design/aes_zsc_round_cell.sv
// One pipeline cell: one AES round plus the matching key expansion step.
module aes_zsc_round_cell import aes_zsc_pkg::*; #(
	parameter bit LastRound = 1'b0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      adv,
	input  cell_bus_t prev,
	output cell_bus_t next
);

	logic [127:0] sub_st;
	logic [127:0] shf_st;
	logic [127:0] mix_st;
	logic [127:0] new_key;
	logic [31:0]  ksub;
	logic         zero_any;
	logic         vld_q;
	logic [127:0] state_q;
	logic [127:0] rkey_q;
	logic [7:0]   rcon_q;
	logic         hit_q;

	always_comb begin
		zero_any = 1'b0;
		for (int k = 0; k < 16; k++) begin
			sub_st[127 - 8*k -: 8] = sbox(byte_of(prev.state, k));
			if (byte_of(prev.state, k) == 8'h00) zero_any = 1'b1;
		end
		// Key word rotation and substitution.
		for (int k = 0; k < 4; k++) begin
			ksub[31 - 8*k -: 8] = sbox(byte_of(prev.rkey, 12 + ((k + 1) % 4)));
			if (byte_of(prev.rkey, 12 + ((k + 1) % 4)) == 8'h00) zero_any = 1'b1;
		end
		ksub[31:24] = ksub[31:24] ^ prev.rcon;
		new_key[127:96] = prev.rkey[127:96] ^ ksub;
		new_key[95:64]  = prev.rkey[95:64] ^ new_key[127:96];
		new_key[63:32]  = prev.rkey[63:32] ^ new_key[95:64];
		new_key[31:0]   = prev.rkey[31:0] ^ new_key[63:32];
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) begin
				shf_st[127 - 8*(c*4 + k) -: 8] = byte_of(sub_st, ((c + k) % 4) * 4 + k);
			end
		end
		for (int c = 0; c < 4; c++) begin
			logic [7:0] a0, a1, a2, a3;
			a0 = byte_of(shf_st, c*4);
			a1 = byte_of(shf_st, c*4 + 1);
			a2 = byte_of(shf_st, c*4 + 2);
			a3 = byte_of(shf_st, c*4 + 3);
			mix_st[127 - 8*(c*4)     -: 8] = xtime(a0 ^ a1) ^ a1 ^ a2 ^ a3;
			mix_st[127 - 8*(c*4 + 1) -: 8] = xtime(a1 ^ a2) ^ a2 ^ a3 ^ a0;
			mix_st[127 - 8*(c*4 + 2) -: 8] = xtime(a2 ^ a3) ^ a3 ^ a0 ^ a1;
			mix_st[127 - 8*(c*4 + 3) -: 8] = xtime(a3 ^ a0) ^ a0 ^ a1 ^ a2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= prev.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			state_q <= (LastRound ? shf_st : mix_st) ^ new_key;
			rkey_q  <= new_key;
			rcon_q  <= xtime(prev.rcon);
			hit_q   <= prev.hit | zero_any;
		end
	end

	assign next = {vld_q, state_q, rkey_q, rcon_q, hit_q};

endmodule

### design/aes128_encrypt_zero_sbox_check_core.sv
// Top level of the AES-128 encryption core with zero S-box input detection.
//
//   channel   direction   payload      handshake
//   in_*      into core   in_item_t    in_valid / in_stall
//   out_*     from core   out_item_t   out_valid / out_stall
//
// Each transaction passes through ten round cells.
// The row of cells accepts a new transaction every cycle unless the input is stalled;
// throughput is one block per clock, set by the single round cell per pipeline stage.
// An output stall freezes the last cell and each full cell behind it; bubbles inside
// the row are squeezed out, and the input is stalled only when cell 0 cannot load.
// Reset clears only the valid bits of the cells.
module aes128_encrypt_zero_sbox_check_core import aes_zsc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	cell_bus_t bus [NumRounds+1];
	logic [NumRounds:0] adv;

	// Cell 0 input: initial AddRoundKey; the first S-box input check is done by cell 0.
	assign bus[0].vld   = in_valid;
	assign bus[0].state = {in_data.text_high, in_data.text_low}
		^ {in_data.key_high, in_data.key_low};
	assign bus[0].rkey  = {in_data.key_high, in_data.key_low};
	assign bus[0].rcon  = 8'h01;
	assign bus[0].hit   = 1'b0;

	// A stage may load when it is empty or its contents move on.
	assign adv[NumRounds] = !out_stall;
	for (genvar i = 0; i < NumRounds; i++) begin : g_adv
		assign adv[i] = adv[i+1] || !bus[i+1].vld;
	end

	assign in_stall = !adv[0];

	for (genvar i = 0; i < NumRounds; i++) begin : g_cell
		aes_zsc_round_cell #(.LastRound(i == NumRounds - 1)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv[i]),
			.prev   (bus[i]),
			.next   (bus[i+1])
		);
	end

	// The flag forces the ciphertext to zero.
	assign out_valid              = bus[NumRounds].vld;
	assign out_data.zero_sbox_hit = bus[NumRounds].hit;
	assign out_data.cipher_high   = bus[NumRounds].hit ? 64'h0 : bus[NumRounds].state[127:64];
	assign out_data.cipher_low    = bus[NumRounds].hit ? 64'h0 : bus[NumRounds].state[63:0];

endmodule

### design/aes_zsc_checker.sv
// Port-level checker for the AES zero S-box core, with its bind statement.
`include "assert_macros.svh"
module aes_zsc_checker import aes_zsc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	`AST_IMPL(a_zero_on_hit, clk, arst_n, out_valid && out_data.zero_sbox_hit, out_data.cipher_high == 64'h0 && out_data.cipher_low == 64'h0, "cipher not zero on hit")
	`AST_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled output changed")
	`AST_IMPL(a_no_stall_free, clk, arst_n, !out_stall, !in_stall, "input stalled while output flows")
	`AST_NEXT(a_in_hold, clk, arst_n, in_valid && in_stall, in_valid, "stalled input dropped")

endmodule

bind aes128_encrypt_zero_sbox_check_core aes_zsc_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
